/* design/plst_pkg.sv */
// plst_pkg: shared types and constants for the positional list store.
// Holds the command, status, state and cell-control types.
// No dependencies; every module of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package plst_pkg;

   localparam int DATA_W         = 32;
   localparam int LIST_DEPTH_DEF = 16;
   localparam int LIST_DEPTH_MAX = 64;
   // wide enough for any count or slot up to LIST_DEPTH_MAX
   localparam int LIST_CNT_W     = $clog2(LIST_DEPTH_MAX + 1);

   typedef enum logic [2:0] {
      OP_INS_HEAD = 3'd0,
      OP_INS_TAIL = 3'd1,
      OP_INS_POS  = 3'd2,
      OP_DEL_HEAD = 3'd3,
      OP_DEL_TAIL = 3'd4,
      OP_DEL_POS  = 3'd5,
      OP_SEARCH   = 3'd6,
      OP_DUMP     = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      STS_OK       = 3'd0,
      STS_EMPTY    = 3'd1,
      STS_FULL     = 3'd2,
      STS_NOTFOUND = 3'd3,
      STS_BADPOS   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_SRCH,
      FSM_DUMP
   } state_type;

   typedef enum logic [1:0] {
      CK_HOLD,
      CK_INS,
      CK_DEL,
      CK_ROT
   } cell_kind_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      cell_kind_type           kind;
      logic [LIST_CNT_W-1:0]   slot;
      logic [LIST_CNT_W-1:0]   used;
      logic [DATA_W-1:0]       value;
   } cell_cmd_type;

endpackage

`default_nettype wire

/* design/plst_cell.sv */
// plst_cell: one storage cell of the list chain.
// Holds one element, shifts from its neighbors and compares against the key.
// Depends on plst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plst_cell #(
   parameter int IDX = 0
) (
   input  wire                         clock,
   input  plst_pkg::cell_cmd_type      cmd,
   input  wire [plst_pkg::DATA_W-1:0]  left_data,
   input  wire [plst_pkg::DATA_W-1:0]  right_data,
   input  wire [plst_pkg::DATA_W-1:0]  head_data,
   output logic [plst_pkg::DATA_W-1:0] data,
   output logic                        match
);
   import plst_pkg::*;

   localparam logic [LIST_CNT_W-1:0] MY_IDX = LIST_CNT_W'(IDX);
   localparam logic [LIST_CNT_W-1:0] MY_NXT = LIST_CNT_W'(IDX + 1);

   logic [DATA_W-1:0] data_ff, data_in;
   logic              match_ff;

   always_comb begin
      data_in = data_ff;
      unique case (cmd.kind)
         CK_INS: begin
            // open a gap at the slot: cells behind it take the left neighbor
            if (MY_IDX > cmd.slot) begin
               data_in = left_data;
            end else if (MY_IDX == cmd.slot) begin
               data_in = cmd.value;
            end
         end
         CK_DEL: begin
            // close the gap: cells from the slot on take the right neighbor
            if (MY_IDX >= cmd.slot) begin
               data_in = right_data;
            end
         end
         CK_ROT: begin
            // rotate the occupied part toward the head
            if (MY_NXT == cmd.used) begin
               data_in = head_data;
            end else if (MY_NXT < cmd.used) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= (data_ff == cmd.value);
   end

   assign data  = data_ff;
   assign match = match_ff;

endmodule

`default_nettype wire

/* design/positional_list_store.sv */
// positional_list_store: top level of the bounded ordered list.
// Sequencer, output register and the chain of plst_cell instances.
// Depends on plst_pkg and plst_cell.
//
// Usage:
//   req channel: one transaction carries one command (op, value, position).
//   rsp channel: status, element, found_at and length per result; tlast
//     marks the final result of a command. A dump of a non-empty list gives
//     one result per element, head first; every other command gives one.
//   Timing: a command is taken in idle and executed in the execute step
//     once the output register is free; no new command is taken until its
//     last result is loaded. A search passes an extra step to resolve the
//     registered match vector of the cell chain. A dump streams one element
//     per cycle while the receiver takes results, by rotating the occupied
//     cells toward the head, and leaves the list in its original order.
//   Reset: synchronous, active high; the element count clears to zero and
//     the sequencer returns to idle. Cell contents are not cleared.
//   Back-pressure: results sit in an output register; while the receiver
//     stalls, the sequencer holds in any step that gives a result and the
//     list does not change.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_store #(
   parameter int DEPTH = plst_pkg::LIST_DEPTH_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // [2:0] op, [34:3] value, [39:35] position
   input  wire  [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [2:0] status, [34:3] element, [39:35] found_at, [44:40] length, [47:45] zero
   output logic [47:0] rsp_tdata,
   output logic        rsp_tlast
);
   import plst_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = ((CNT_W > 5) ? CNT_W : 5) + 1;
   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

   // command latch
   op_type            op_ff;
   logic [DATA_W-1:0] value_ff;
   logic [4:0]        pos_ff;

   // control state
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [47:0]       rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   // cell chain
   cell_cmd_type      cmd;
   logic [DATA_W-1:0] cell_data [DEPTH];
   logic [DEPTH-1:0]  match_vec;

   logic              req_fire;
   logic              out_free;
   logic [CMP_W-1:0]  used_c, pos_c, cnt_c, hit_pos;

   // per-step result selection
   logic              emit;
   status_type        st_code;
   logic [DATA_W-1:0] elem;
   logic [4:0]        fnd;
   logic              last_bit;

   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign used_c   = CMP_W'(used_ff);
   assign pos_c    = CMP_W'(pos_ff);
   assign cnt_c    = CMP_W'(cnt_ff);

   // first match among occupied cells; scan from the tail so the head wins
   always_comb begin
      hit_pos = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match_vec[i] && (CMP_W'(i) < used_c)) begin
            hit_pos = CMP_W'(i + 1);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      cnt_in       = cnt_ff;
      req_tready   = (state_ff == FSM_IDLE);
      emit         = 1'b0;
      st_code      = STS_OK;
      elem         = '0;
      fnd          = '0;
      last_bit     = 1'b1;
      cmd.kind     = CK_HOLD;
      cmd.slot     = '0;
      cmd.used     = LIST_CNT_W'(used_ff);
      cmd.value    = value_ff;

      unique case (state_ff)
         FSM_IDLE: begin
            if (req_fire) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            unique case (op_ff)
               OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     state_in = FSM_IDLE;
                     priority if (used_c == DEPTH_C) begin
                        st_code = STS_FULL;
                     end else if (op_ff == OP_INS_POS &&
                                  (pos_c == '0 || pos_c > used_c + 1'b1)) begin
                        st_code = STS_BADPOS;
                     end else begin
                        cmd.kind = CK_INS;
                        if (op_ff == OP_INS_TAIL) begin
                           cmd.slot = LIST_CNT_W'(used_c);
                        end else if (op_ff == OP_INS_POS) begin
                           cmd.slot = LIST_CNT_W'(pos_c - 1'b1);
                        end
                        used_in = CNT_W'(used_c + 1'b1);
                     end
                  end
               end
               OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_POS: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     state_in = FSM_IDLE;
                     priority if (used_c == '0) begin
                        st_code = STS_EMPTY;
                     end else if (op_ff == OP_DEL_POS &&
                                  (pos_c == '0 || pos_c > used_c)) begin
                        st_code = STS_BADPOS;
                     end else begin
                        cmd.kind = CK_DEL;
                        if (op_ff == OP_DEL_TAIL) begin
                           cmd.slot = LIST_CNT_W'(used_c - 1'b1);
                        end else if (op_ff == OP_DEL_POS) begin
                           cmd.slot = LIST_CNT_W'(pos_c - 1'b1);
                        end
                        used_in = CNT_W'(used_c - 1'b1);
                     end
                  end
               end
               OP_SEARCH: begin
                  if (used_c != '0) begin
                     // cells register their compare this cycle
                     state_in = FSM_SRCH;
                  end else if (out_free) begin
                     emit     = 1'b1;
                     st_code  = STS_EMPTY;
                     state_in = FSM_IDLE;
                  end
               end
               OP_DUMP: begin
                  if (used_c != '0) begin
                     cnt_in   = '0;
                     state_in = FSM_DUMP;
                  end else if (out_free) begin
                     emit     = 1'b1;
                     st_code  = STS_EMPTY;
                     state_in = FSM_IDLE;
                  end
               end
               default: begin
                  state_in = FSM_IDLE;
               end
            endcase
         end
         FSM_SRCH: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = FSM_IDLE;
               if (hit_pos != '0) begin
                  st_code = STS_OK;
                  fnd     = hit_pos[4:0];
               end else begin
                  st_code = STS_NOTFOUND;
               end
            end
         end
         FSM_DUMP: begin
            last_bit = (cnt_c + 1'b1 == used_c);
            if (out_free) begin
               emit     = 1'b1;
               elem     = cell_data[0];
               cmd.kind = CK_ROT;
               cnt_in   = CNT_W'(cnt_c + 1'b1);
               if (last_bit) begin
                  state_in = FSM_IDLE;
               end
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // output register: load on a result, drop on a taken transaction
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'b000, 5'(CMP_W'(used_in)), fnd, elem, st_code};
         rsp_last_in  = last_bit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         used_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (req_fire) begin
         op_ff    <= op_type'(req_tdata[2:0]);
         value_ff <= req_tdata[34:3];
         pos_ff   <= req_tdata[39:35];
      end
   end

   // chain of cells; the ends see their own data as the missing neighbor
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_W-1:0] left_w, right_w;
      if (g == 0) begin : g_first
         assign left_w = cell_data[g];
      end else begin : g_mid_l
         assign left_w = cell_data[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_w = cell_data[g];
      end else begin : g_mid_r
         assign right_w = cell_data[g+1];
      end
      plst_cell #(
         .IDX (g)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_data  (left_w),
         .right_data (right_w),
         .head_data  (cell_data[0]),
         .data       (cell_data[g]),
         .match      (match_vec[g])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

/* test/testbench.sv */
// testbench: self-checking bench for positional_list_store.
// Drives list commands, predicts every result with a queue model and checks the rsp stream.
// Depends on plst_pkg and the positional_list_store RTL.
`timescale 1ns / 1ps

module testbench;
   import plst_pkg::*;

   localparam int LIST_DEPTH = LIST_DEPTH_DEF;

   typedef struct {
      status_type  status;
      logic [31:0] element;
      logic [4:0]  found_at;
      logic [4:0]  length;
      logic        last;
   } list_result_type;

   // Predicts the list contents and queues the results each command should produce.
   class list_scoreboard;
      logic [31:0]     cells[$];
      list_result_type awaited[$];
      int              capacity;
      int              errors;
      int              checked;
      int              op_seen[8];
      int              status_seen[5];

      function new(int cap);
         capacity = cap;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void queue_result(status_type st, logic [31:0] el, logic [4:0] at, logic fin);
         list_result_type r;
         r.status   = st;
         r.element  = el;
         r.found_at = at;
         r.length   = 5'(cells.size());
         r.last     = fin;
         awaited.push_back(r);
         status_seen[int'(st)]++;
      endfunction

      // Apply one accepted command to the predicted list.
      function void note_command(op_type op, logic [31:0] value, logic [4:0] position);
         int n;
         int hit;
         n = cells.size();
         op_seen[int'(op)]++;
         case (op)
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
               // full takes priority over a bad position
               if (n >= capacity) begin
                  queue_result(STS_FULL, 0, 0, 1'b1);
               end else if (op == OP_INS_POS && (position < 1 || position > n + 1)) begin
                  queue_result(STS_BADPOS, 0, 0, 1'b1);
               end else begin
                  if (op == OP_INS_HEAD) cells.push_front(value);
                  else if (op == OP_INS_TAIL) cells.push_back(value);
                  else cells.insert(position - 1, value);
                  queue_result(STS_OK, 0, 0, 1'b1);
               end
            end
            OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_POS: begin
               // empty takes priority over a bad position
               if (n == 0) begin
                  queue_result(STS_EMPTY, 0, 0, 1'b1);
               end else if (op == OP_DEL_POS && (position < 1 || position > n)) begin
                  queue_result(STS_BADPOS, 0, 0, 1'b1);
               end else begin
                  if (op == OP_DEL_HEAD) cells.delete(0);
                  else if (op == OP_DEL_TAIL) cells.delete(n - 1);
                  else cells.delete(position - 1);
                  queue_result(STS_OK, 0, 0, 1'b1);
               end
            end
            OP_SEARCH: begin
               if (n == 0) begin
                  queue_result(STS_EMPTY, 0, 0, 1'b1);
               end else begin
                  hit = 0;
                  for (int i = 0; i < n && hit == 0; i++) begin
                     if (cells[i] === value) hit = i + 1;
                  end
                  if (hit != 0) queue_result(STS_OK, 0, 5'(hit), 1'b1);
                  else queue_result(STS_NOTFOUND, 0, 0, 1'b1);
               end
            end
            default: begin
               if (n == 0) begin
                  queue_result(STS_EMPTY, 0, 0, 1'b1);
               end else begin
                  for (int i = 0; i < n; i++) begin
                     queue_result(STS_OK, cells[i], 0, i == n - 1);
                  end
               end
            end
         endcase
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
         end
      endfunction

      // Check one delivered result against the oldest prediction.
      function void check_result(logic [47:0] data, logic fin);
         list_result_type want;
         if (awaited.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, actual tdata %h last %b",
                     $time, data, fin);
            return;
         end
         want = awaited.pop_front();
         checked++;
         compare_field("status", 32'(want.status), 32'(data[2:0]));
         compare_field("element", want.element, data[34:3]);
         compare_field("found_at", 32'(want.found_at), 32'(data[39:35]));
         compare_field("length", 32'(want.length), 32'(data[44:40]));
         compare_field("last", 32'(want.last), 32'(fin));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;

   list_scoreboard sb;
   int  commands_sent = 0;
   bit  sender_idles = 1'b1;
   bit  receiver_idles = 1'b1;
   bit  hold_request = 1'b0;
   int  hold_left = 0;

   positional_list_store #(.DEPTH(LIST_DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Receiver: random stalls, plus a long hold-off counted here on request.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = 80;
      end
      if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!receiver_idles) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 25);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
   end

   // Offer one command and hold it until the block takes the transaction.
   task automatic send_command(op_type op, logic [31:0] value, logic [4:0] position);
      @(negedge clock);
      while (sender_idles && $urandom_range(99) < 25) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {position, value, op};
      do @(posedge clock); while (!req_tready);
      sb.note_command(op, value, position);
      commands_sent++;
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         // a narrow cluster so duplicates and search hits are common
         3, 4, 5, 6: return 32'($urandom_range(7)) - 32'd3;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] pick_search_value();
      if (sb.cells.size() > 0 && $urandom_range(9) < 6)
         return sb.cells[$urandom_range(sb.cells.size() - 1)];
      return pick_value();
   endfunction

   // Mostly legal positions; now and then anything the field can carry.
   function automatic logic [4:0] pick_position(int limit);
      if (limit >= 1 && $urandom_range(3) != 0) return 5'($urandom_range(limit, 1));
      return 5'($urandom_range(31, 0));
   endfunction

   initial begin
      int     ep;
      int     kind;
      int     steps;
      int     target;
      op_type op;

      sb = new(LIST_DEPTH);
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // directed: empty list, position limits, extremes, every op
      send_command(OP_DUMP, 32'h0, 5'd1);
      send_command(OP_SEARCH, 32'h0, 5'd1);
      send_command(OP_DEL_HEAD, 32'h0, 5'd1);
      send_command(OP_DEL_TAIL, 32'h0, 5'd1);
      send_command(OP_DEL_POS, 32'h0, 5'd31);
      send_command(OP_INS_POS, 32'h8000_0000, 5'd1);
      send_command(OP_INS_POS, 32'h1, 5'd0);
      send_command(OP_INS_POS, 32'h2, 5'd31);
      send_command(OP_INS_HEAD, 32'h7FFF_FFFF, 5'd0);
      send_command(OP_INS_TAIL, 32'hFFFF_FFFF, 5'd16);
      send_command(OP_INS_POS, 32'h5555_5555, 5'd2);
      send_command(OP_INS_POS, 32'hAAAA_AAAA, 5'd5);
      send_command(OP_INS_POS, 32'h3, 5'd7);
      send_command(OP_SEARCH, 32'hFFFF_FFFF, 5'd0);
      send_command(OP_SEARCH, 32'h0000_1234, 5'd0);
      send_command(OP_DUMP, 32'h0, 5'd0);
      send_command(OP_DEL_POS, 32'h0, 5'd0);
      send_command(OP_DEL_POS, 32'h0, 5'd6);
      send_command(OP_DEL_POS, 32'h0, 5'd2);
      send_command(OP_DEL_HEAD, 32'h0, 5'd0);
      send_command(OP_DEL_TAIL, 32'h0, 5'd0);
      send_command(OP_DUMP, 32'h0, 5'd0);

      // random: fill, drain, mixed and dump episodes
      ep     = 0;
      target = commands_sent + 120;
      while (commands_sent < target) begin
         sender_idles   = !(ep >= 6 && ep < 10);
         receiver_idles = sender_idles;
         kind = (ep == 0) ? 0 : $urandom_range(3);
         if (ep == 3) begin
            // stall the receiver while commands keep coming
            hold_request = 1'b1;
            kind = 2;
         end
         if (ep == 8) wait_for_drain();
         case (kind)
            0: begin
               while (sb.cells.size() < LIST_DEPTH) begin
                  op = op_type'($urandom_range(2));
                  send_command(op, pick_value(), pick_position(sb.cells.size() + 1));
               end
               repeat (2) send_command(op_type'($urandom_range(2)), pick_value(),
                                       5'($urandom_range(31, 0)));
            end
            1: begin
               while (sb.cells.size() > 0) begin
                  op = op_type'($urandom_range(5, 3));
                  send_command(op, pick_value(), pick_position(sb.cells.size()));
               end
               repeat (2) send_command(op_type'($urandom_range(7, 3)), pick_value(),
                                       pick_position(1));
            end
            2: begin
               steps = $urandom_range(10, 4);
               repeat (steps) begin
                  op = op_type'($urandom_range(7));
                  if (op == OP_SEARCH)
                     send_command(op, pick_search_value(), pick_position(16));
                  else if (op inside {OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS})
                     send_command(op, pick_value(), pick_position(sb.cells.size() + 1));
                  else
                     send_command(op, pick_value(), pick_position(sb.cells.size()));
               end
            end
            default: begin
               send_command(OP_DUMP, pick_value(), pick_position(16));
               send_command(OP_SEARCH, pick_search_value(), pick_position(16));
            end
         endcase
         ep++;
      end

      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      wait_for_drain();
      repeat (20) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.errors += sb.pending();
         $display("%0t: %0d expected results never arrived", $time, sb.pending());
      end

      $display("ran %0d commands: inserts %0d/%0d/%0d, deletes %0d/%0d/%0d, search %0d, dump %0d",
               commands_sent, sb.op_seen[0], sb.op_seen[1], sb.op_seen[2], sb.op_seen[3],
               sb.op_seen[4], sb.op_seen[5], sb.op_seen[6], sb.op_seen[7]);
      $display("checked %0d results: ok %0d, empty %0d, full %0d, not found %0d, bad position %0d",
               sb.checked, sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
               sb.status_seen[3], sb.status_seen[4]);
      if (sb.errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule

/* sim.f */
design/plst_pkg.sv
design/plst_cell.sv
design/positional_list_store.sv
test/testbench.sv
